[src/sds_pkg.sv]
`default_nettype none
package sds_pkg;

  localparam int MAX_SPRITES = 64;
  localparam int ADDR_W      = $clog2(MAX_SPRITES);
  localparam int CNT_W       = $clog2(MAX_SPRITES + 1);
  localparam int IDX_W       = 6;
  localparam int COORD_W     = 16;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int DIST_W      = SQ_W + 1;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic REG_PLAYER_X = 1'b0;
  localparam logic REG_PLAYER_Y = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_dist;
  } ram_word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    ram_word_t         wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

[src/sds_cfg.sv]
`default_nettype none
module sds_cfg
  import sds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [COORD_W-1:0] player_x,
  output logic      [COORD_W-1:0] player_y
);

  logic [COORD_W-1:0] player_x_r;
  logic [COORD_W-1:0] player_y_r;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= '0;
      player_y_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PLAYER_X: player_x_r <= pwdata[COORD_W-1:0];
        REG_PLAYER_Y: player_y_r <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PLAYER_X: prdata = {{(PDATA_W-COORD_W){1'b0}}, player_x_r};
      REG_PLAYER_Y: prdata = {{(PDATA_W-COORD_W){1'b0}}, player_y_r};
      default:      prdata = '0;
    endcase
  end

  assign player_x = player_x_r;
  assign player_y = player_y_r;

endmodule
`default_nettype wire

[src/sds_dist.sv]
`default_nettype none
module sds_dist
  import sds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic [COORD_W-1:0] sprite_x,
  input  wire logic [COORD_W-1:0] sprite_y,
  input  wire logic [COORD_W-1:0] player_x,
  input  wire logic [COORD_W-1:0] player_y,
  output logic      [DIST_W-1:0]  sq_dist
);

  logic [COORD_W-1:0] dx_r;
  logic [COORD_W-1:0] dy_r;
  logic [SQ_W-1:0]    sqx_r;
  logic [SQ_W-1:0]    sqy_r;

  // Differences are taken against the player position present at accept.
  always_ff @(posedge clk) begin
    if (load) begin
      dx_r <= (player_x >= sprite_x) ? (player_x - sprite_x) : (sprite_x - player_x);
      dy_r <= (player_y >= sprite_y) ? (player_y - sprite_y) : (sprite_y - player_y);
    end
    sqx_r <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r <= SQ_W'(dy_r) * SQ_W'(dy_r);
  end

  assign sq_dist = {1'b0, sqx_r} + {1'b0, sqy_r};

endmodule
`default_nettype wire

[src/sds_ram.sv]
`default_nettype none
module sds_ram
  import sds_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t req,
  output ram_word_t     rdata
);

  ram_word_t mem [MAX_SPRITES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

[src/sds_seq.sv]
`default_nettype none
module sds_seq
  import sds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              final_sprite,
  output logic                   busy,
  output logic                   load,
  input  wire logic [DIST_W-1:0] sq_dist,
  output ram_req_t               ram_req,
  input  wire ram_word_t         rdata,
  output logic                   out_strobe,
  output logic      [IDX_W-1:0]  out_index,
  output logic      [DIST_W-1:0] out_dist,
  output logic                   out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_SQ,
    S_LD_WR,
    S_CAPI,
    S_SCAN,
    S_WBI,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              fin_r, fin_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  ram_word_t         cur_r, cur_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic              out_strobe_r;
  logic              out_last_r;
  ram_word_t         out_word_r;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  last_pos;

  assign busy      = (state_r != S_IDLE);
  assign load      = start & (state_r == S_IDLE);
  assign count_inc = count_r + CNT_W'(1);
  assign last_pos  = count_r - CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    fin_nxt       = fin_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    rd_vld_nxt    = 1'b0;
    rd_last_nxt   = 1'b0;
    ram_req       = '0;
    ram_req.raddr = i_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          fin_nxt   = final_sprite;
          state_nxt = S_LD_SQ;
        end
      end
      S_LD_SQ: begin
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        // A full store drops the sprite, but a final item still runs the sort.
        if (count_r < CNT_W'(MAX_SPRITES)) begin
          ram_req.we            = 1'b1;
          ram_req.waddr         = count_r[ADDR_W-1:0];
          ram_req.wdata.idx     = IDX_W'(count_r);
          ram_req.wdata.sq_dist = sq_dist;
          count_nxt             = count_inc;
        end
        i_nxt         = '0;
        k_nxt         = '0;
        ram_req.raddr = '0;
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (count_nxt >= CNT_W'(2)) begin
          state_nxt = S_CAPI;
        end else if (count_nxt == CNT_W'(1)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CAPI: begin
        cur_nxt       = rdata;
        j_nxt         = i_r + ADDR_W'(1);
        ram_req.raddr = i_r + ADDR_W'(1);
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (rdata.sq_dist > cur_r.sq_dist) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = j_r;
          ram_req.wdata = cur_r;
          cur_nxt       = rdata;
        end
        if ({1'b0, j_r} == last_pos) begin
          state_nxt = S_WBI;
        end else begin
          j_nxt         = j_r + ADDR_W'(1);
          ram_req.raddr = j_r + ADDR_W'(1);
        end
      end
      S_WBI: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = i_r;
        ram_req.wdata = cur_r;
        ram_req.raddr = i_r + ADDR_W'(1);
        if (({1'b0, i_r} + CNT_W'(2)) < count_r) begin
          i_nxt     = i_r + ADDR_W'(1);
          state_nxt = S_CAPI;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        ram_req.raddr = k_r;
        rd_vld_nxt    = 1'b1;
        rd_last_nxt   = ({1'b0, k_r} == last_pos);
        if ({1'b0, k_r} == last_pos) begin
          count_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + ADDR_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rd_vld_r     <= rd_vld_nxt;
      rd_last_r    <= rd_last_nxt;
      out_strobe_r <= rd_vld_r;
      out_last_r   <= rd_vld_r & rd_last_r;
    end
    fin_r <= fin_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    cur_r <= cur_nxt;
    if (rd_vld_r) begin
      out_word_r <= rdata;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_index  = out_word_r.idx;
  assign out_dist   = out_word_r.sq_dist;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

[src/sprite_distance_sort.sv]
`default_nettype none
// Sprite distance sort.
//
// Sprites arrive one word at a time on the command channel: a word is taken
// at a clock edge where start is high and busy is low. Each sprite gets its
// arrival number and its squared distance to the player position held in
// the player_x and player_y registers (APB port, byte addresses 0 and 4).
// Loading one sprite keeps busy high after the accepting edge (difference,
// then square, then sum and store), so a new sprite word is taken only after
// the last one is stored. After the word flagged final_sprite the stored
// entries are sorted far to near in the single on-chip memory, one compare
// per cycle; this read-compare-write loop over the memory port sets the
// rate. Results then leave one per cycle, n words for n sprites marked by
// out_strobe, each read from the memory and then registered at the output,
// with out_last_result on the nearest sprite. The receiver cannot stall:
// each word is present for exactly one cycle. Up to 64 sprites are held;
// further sprites of a set are dropped. A synchronous reset (rst_n low)
// clears the sprite count, the player registers and the control state; the
// memory itself is not cleared, since only written entries are ever used.
module sprite_distance_sort
  import sds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [COORD_W-1:0] in_sprite_x,
  input  wire logic [COORD_W-1:0] in_sprite_y,
  input  wire logic               in_final_sprite,
  output logic                    out_strobe,
  output logic      [IDX_W-1:0]   out_sprite_index,
  output logic      [DIST_W-1:0]  out_squared_distance,
  output logic                    out_last_result
);

  logic [COORD_W-1:0] player_x;
  logic [COORD_W-1:0] player_y;
  logic               load;
  logic [DIST_W-1:0]  sq_dist;
  ram_req_t           ram_req;
  ram_word_t          ram_rdata;

  sds_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .player_x (player_x),
    .player_y (player_y)
  );

  // Distance pipeline: absolute differences, registered squares, then the sum
  // is written straight into the memory.
  sds_dist u_dist (
    .clk      (clk),
    .load     (load),
    .sprite_x (in_sprite_x),
    .sprite_y (in_sprite_y),
    .player_x (player_x),
    .player_y (player_y),
    .sq_dist  (sq_dist)
  );

  // One write port and one registered read port. The only cycle in which the
  // sequencer reads and writes the same entry is the store of sprite 0, and
  // that read data is never used, so no bypass is needed.
  sds_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // The sort keeps entry i in a register while entries j > i stream past it;
  // a larger entry is swapped into the register and the old one written back
  // at j, and entry i is written once at the end of its pass.
  sds_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .final_sprite (in_final_sprite),
    .busy         (busy),
    .load         (load),
    .sq_dist      (sq_dist),
    .ram_req      (ram_req),
    .rdata        (ram_rdata),
    .out_strobe   (out_strobe),
    .out_index    (out_sprite_index),
    .out_dist     (out_squared_distance),
    .out_last     (out_last_result)
  );

endmodule
`default_nettype wire

[src/sds_check.sv]
`default_nettype none
module sds_check (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic pready,
  input wire logic out_strobe,
  input wire logic out_last_result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted word");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result |-> out_strobe)
    else $error("last flag without a result strobe");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_result) |=> !out_strobe)
    else $error("result strobe right after the last result");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind sprite_distance_sort sds_check u_sds_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .pready          (pready),
  .out_strobe      (out_strobe),
  .out_last_result (out_last_result)
);
`default_nettype wire
